// File: rtl/crfr_pkg.sv
package crfr_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_START_BYTE    = 2'd0;
    localparam logic [1:0] CFG_MAX_DATA_LEN  = 2'd1;
    localparam logic [1:0] CFG_MAX_KEY_LEN   = 2'd2;
    localparam logic [1:0] CFG_MAX_NONCE_LEN = 2'd3;

    localparam logic [7:0]  START_BYTE_RST    = 8'd74;
    localparam logic [15:0] MAX_DATA_LEN_RST  = 16'd1024;
    localparam logic [7:0]  MAX_KEY_LEN_RST   = 8'd32;
    localparam logic [7:0]  MAX_NONCE_LEN_RST = 8'd24;

    localparam logic [7:0] CRC_POLY = 8'h07;
    localparam logic [7:0] CRC_INIT = 8'h00;

    // Section codes
    localparam logic [1:0] SEC_DATA  = 2'd0;
    localparam logic [1:0] SEC_KEY   = 2'd1;
    localparam logic [1:0] SEC_NONCE = 2'd2;
    localparam logic [1:0] SEC_REPLY = 2'd3;

    // Status codes
    localparam logic [1:0] ST_BUSY     = 2'd0;
    localparam logic [1:0] ST_OK       = 2'd1;
    localparam logic [1:0] ST_CRC_ERR  = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    localparam logic [7:0] REPLY_ACK  = 8'd1;
    localparam logic [7:0] REPLY_NACK = 8'd0;

    localparam logic [2:0] HDR_LAST_IDX = 3'd4;

    // Reply frame beat positions
    localparam logic [1:0] BEAT_START = 2'd0;
    localparam logic [1:0] BEAT_ACK   = 2'd1;
    localparam logic [1:0] BEAT_CRC   = 2'd2;

    // Command queue between parser and emitter
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_HDR,
        PH_DATA,
        PH_KEY,
        PH_NONCE,
        PH_CRC
    } phase_t;

    typedef struct packed {
        logic        is_reply;
        logic [1:0]  section;
        logic [7:0]  value;     // payload byte, or ack code for a reply
        logic [15:0] offset;
        logic [1:0]  status;
        logic [7:0]  algorithm;
        logic [15:0] data_len;
        logic [7:0]  key_len;
        logic [7:0]  nonce_len;
    } qent_t;

    typedef struct packed {
        logic [7:0]  start_byte;
        logic [15:0] max_data_len;
        logic [7:0]  max_key_len;
        logic [7:0]  max_nonce_len;
    } cfg_t;

    // CRC-8, MSB first, one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] c, input logic [7:0] b);
        logic [7:0] v;
        v = c ^ b;
        for (int i = 0; i < 8; i++) begin
            if (v[7])
            begin
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

// File: rtl/crfr_front.sv
module crfr_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_go,
    input  logic               mode,
    input  logic [7:0]         rx_byte,
    input  crfr_pkg::cfg_t     cfg,
    output logic               push,
    output crfr_pkg::qent_t    push_ent
);
    import crfr_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [2:0]  hdr_idx_reg, hdr_idx_next;
    logic [7:0]  crc_reg, crc_next;
    logic [7:0]  algo_reg, algo_next;
    logic [15:0] data_len_reg, data_len_next;
    logic [7:0]  key_len_reg, key_len_next;
    logic [7:0]  nonce_len_reg, nonce_len_next;
    logic [15:0] count_reg, count_next;

    logic        take;
    logic        timeout;
    logic        hdr_done;
    logic        overflow;
    logic        sec_end;
    logic        crc_ok;
    logic [7:0]  crc_upd;
    logic [15:0] sec_len;
    logic [1:0]  sec_code;

    // First non-empty section at or after the given one
    function automatic phase_t first_section(input phase_t from, input logic [15:0] dl,
                                             input logic [7:0] kl, input logic [7:0] nl);
        phase_t p;
        p = PH_CRC;
        if (from == PH_DATA && dl != '0)
        begin
            p = PH_DATA;
        end
        else if ((from == PH_DATA || from == PH_KEY) && kl != '0)
        begin
            p = PH_KEY;
        end
        else if (from != PH_CRC && nl != '0)
        begin
            p = PH_NONCE;
        end
        return p;
    endfunction

    assign take     = in_valid && in_go;
    assign timeout  = mode;
    assign crc_upd  = crc8_byte(crc_reg, rx_byte);
    assign crc_ok   = (crc_reg == rx_byte);
    assign hdr_done = (hdr_idx_reg == HDR_LAST_IDX);
    // nonce length arrives with the last header byte
    assign overflow = (key_len_reg > cfg.max_key_len) || (rx_byte > cfg.max_nonce_len)
                   || (data_len_reg > cfg.max_data_len);

    always_comb
    begin
        case (phase_reg)
            PH_DATA:  begin sec_len = data_len_reg;           sec_code = SEC_DATA;  end
            PH_KEY:   begin sec_len = {8'd0, key_len_reg};    sec_code = SEC_KEY;   end
            default:  begin sec_len = {8'd0, nonce_len_reg};  sec_code = SEC_NONCE; end
        endcase
    end

    assign sec_end = ({1'b0, count_reg} + 17'd1) >= {1'b0, sec_len};

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (take)
        begin
            if (timeout)
            begin
                phase_next = PH_HUNT;
            end
            else
            begin
                case (phase_reg)
                    PH_HUNT:
                    begin
                        if (rx_byte == cfg.start_byte)
                        begin
                            phase_next = PH_HDR;
                        end
                    end
                    PH_HDR:
                    begin
                        if (hdr_done)
                        begin
                            phase_next = overflow ? PH_HUNT
                                : first_section(PH_DATA, data_len_reg, key_len_reg, rx_byte);
                        end
                    end
                    PH_DATA:
                    begin
                        if (sec_end)
                        begin
                            phase_next = first_section(PH_KEY, data_len_reg, key_len_reg,
                                                       nonce_len_reg);
                        end
                    end
                    PH_KEY:
                    begin
                        if (sec_end)
                        begin
                            phase_next = first_section(PH_NONCE, data_len_reg, key_len_reg,
                                                       nonce_len_reg);
                        end
                    end
                    PH_NONCE:
                    begin
                        if (sec_end)
                        begin
                            phase_next = PH_CRC;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_HUNT;
                    end
                endcase
            end
        end
    end

    // Datapath and queue writes
    always_comb
    begin
        hdr_idx_next   = hdr_idx_reg;
        crc_next       = crc_reg;
        algo_next      = algo_reg;
        data_len_next  = data_len_reg;
        key_len_next   = key_len_reg;
        nonce_len_next = nonce_len_reg;
        count_next     = count_reg;
        push           = 1'b0;
        push_ent.is_reply  = 1'b0;
        push_ent.section   = sec_code;
        push_ent.value     = rx_byte;
        push_ent.offset    = count_reg;
        push_ent.status    = ST_BUSY;
        push_ent.algorithm = algo_reg;
        push_ent.data_len  = data_len_reg;
        push_ent.key_len   = key_len_reg;
        push_ent.nonce_len = nonce_len_reg;
        if (take)
        begin
            if (timeout)
            begin
                hdr_idx_next = '0;
                count_next   = '0;
                crc_next     = CRC_INIT;
            end
            else
            begin
                case (phase_reg)
                    PH_HUNT:
                    begin
                        if (rx_byte == cfg.start_byte)
                        begin
                            hdr_idx_next = '0;
                            count_next   = '0;
                            crc_next     = crc8_byte(CRC_INIT, rx_byte);
                        end
                    end
                    PH_HDR:
                    begin
                        crc_next = crc_upd;
                        case (hdr_idx_reg)
                            3'd0:    algo_next = rx_byte;
                            3'd1:    data_len_next = {rx_byte, data_len_reg[7:0]};
                            3'd2:    data_len_next = {data_len_reg[15:8], rx_byte};
                            3'd3:    key_len_next = rx_byte;
                            default: nonce_len_next = rx_byte;
                        endcase
                        if (hdr_done)
                        begin
                            hdr_idx_next = '0;
                            count_next   = '0;
                            if (overflow)
                            begin
                                crc_next           = CRC_INIT;
                                push               = 1'b1;
                                push_ent.is_reply  = 1'b1;
                                push_ent.section   = SEC_REPLY;
                                push_ent.value     = REPLY_NACK;
                                push_ent.status    = ST_OVERFLOW;
                                push_ent.nonce_len = rx_byte;
                            end
                        end
                        else
                        begin
                            hdr_idx_next = hdr_idx_reg + 3'd1;
                        end
                    end
                    PH_DATA, PH_KEY, PH_NONCE:
                    begin
                        crc_next   = crc_upd;
                        push       = 1'b1;
                        count_next = sec_end ? '0 : count_reg + 16'd1;
                    end
                    default:
                    begin
                        crc_next          = CRC_INIT;
                        count_next        = '0;
                        push              = 1'b1;
                        push_ent.is_reply = 1'b1;
                        push_ent.section  = SEC_REPLY;
                        push_ent.value    = crc_ok ? REPLY_ACK : REPLY_NACK;
                        push_ent.status   = crc_ok ? ST_OK : ST_CRC_ERR;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            hdr_idx_reg   <= '0;
            crc_reg       <= CRC_INIT;
            algo_reg      <= '0;
            data_len_reg  <= '0;
            key_len_reg   <= '0;
            nonce_len_reg <= '0;
            count_reg     <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            hdr_idx_reg   <= hdr_idx_next;
            crc_reg       <= crc_next;
            algo_reg      <= algo_next;
            data_len_reg  <= data_len_next;
            key_len_reg   <= key_len_next;
            nonce_len_reg <= nonce_len_next;
            count_reg     <= count_next;
        end
    end

endmodule

// File: rtl/crfr_queue.sv
module crfr_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  crfr_pkg::qent_t   push_ent,
    input  logic              pop,
    output logic              full,
    output logic              nonempty,
    output crfr_pkg::qent_t   head
);
    import crfr_pkg::*;

    qent_t          mem_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]   count_reg, count_next;

    assign full     = (count_reg == QAW'(0) + (QAW+1)'(QDEPTH));
    assign nonempty = (count_reg != '0);
    assign head     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QAW+1)'(push) - (QAW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_ent;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/crfr_back.sv
module crfr_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_nonempty,
    input  crfr_pkg::qent_t   q_head,
    output logic              pop,
    input  logic [7:0]        start_byte,
    input  logic              out_stall,
    output logic              out_valid,
    output logic [1:0]        section,
    output logic [7:0]        value,
    output logic [15:0]       offset,
    output logic [1:0]        status,
    output logic [7:0]        algorithm,
    output logic [15:0]       data_len,
    output logic [7:0]        key_len,
    output logic [7:0]        nonce_len,
    output logic              last
);
    import crfr_pkg::*;

    qent_t      cur_reg, cur_next;
    logic       cur_valid_reg, cur_valid_next;
    logic [1:0] beat_reg, beat_next;
    logic       sent;
    logic       final_beat;
    logic [7:0] reply_crc;

    assign sent       = cur_valid_reg && !out_stall;
    assign final_beat = !cur_reg.is_reply || (beat_reg == BEAT_CRC);
    assign pop        = q_nonempty && (!cur_valid_reg || (sent && final_beat));
    assign reply_crc  = crc8_byte(crc8_byte(CRC_INIT, start_byte), cur_reg.value);

    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        beat_next      = beat_reg;
        if (pop)
        begin
            cur_next       = q_head;
            cur_valid_next = 1'b1;
            beat_next      = BEAT_START;
        end
        else if (sent)
        begin
            if (final_beat)
            begin
                cur_valid_next = 1'b0;
            end
            else
            begin
                beat_next = beat_reg + 2'd1;
            end
        end
    end

    always_comb
    begin
        out_valid = cur_valid_reg;
        section   = cur_reg.section;
        status    = cur_reg.status;
        algorithm = cur_reg.algorithm;
        data_len  = cur_reg.data_len;
        key_len   = cur_reg.key_len;
        nonce_len = cur_reg.nonce_len;
        value     = cur_reg.value;
        offset    = cur_reg.offset;
        last      = 1'b0;
        if (cur_reg.is_reply)
        begin
            offset = {14'd0, beat_reg};
            last   = (beat_reg == BEAT_CRC);
            case (beat_reg)
                BEAT_START: value = start_byte;
                BEAT_ACK:   value = cur_reg.value;
                default:    value = reply_crc;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            beat_reg      <= BEAT_START;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            beat_reg      <= beat_next;
        end
    end

endmodule

// File: rtl/crc8_request_frame_receiver_core.sv
// Channel   Dir  Handshake            Payload
// -------   ---  -------------------  ------------------------------------------------
// in        in   in_valid / in_stall  mode, rx_byte
// out       out  out_valid/out_stall  section, value, offset, status, algorithm,
//                                     data_len, key_len, nonce_len, last
// cfg       in   cfg_we               cfg_index, cfg_data
//
// One received byte or timeout is taken per cycle while the four-entry command queue
// has room; the frame parser updates CRC and section state in that same cycle.
// Payload bytes leave one per cycle while out_stall is low; a reply frame is three output
// transfers, the start, ack and CRC beats that the emitter walks from one queue entry.
// Reset is asynchronous and clears parser state, queue pointers and the output valid;
// there is no clearing pass. in_stall rises only when the queue is full.
module crc8_request_frame_receiver_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  section,
    output logic [7:0]  value,
    output logic [15:0] offset,
    output logic [1:0]  status,
    output logic [7:0]  algorithm,
    output logic [15:0] data_len,
    output logic [7:0]  key_len,
    output logic [7:0]  nonce_len,
    output logic        last,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import crfr_pkg::*;

    cfg_t  cfg_reg, cfg_next;
    logic  q_full;
    logic  q_nonempty;
    logic  q_push;
    logic  q_pop;
    qent_t q_push_ent;
    qent_t q_head;

    // Register writes: mask data to each register's width
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_START_BYTE:    cfg_next.start_byte    = cfg_data[7:0];
                CFG_MAX_DATA_LEN:  cfg_next.max_data_len  = cfg_data;
                CFG_MAX_KEY_LEN:   cfg_next.max_key_len   = cfg_data[7:0];
                CFG_MAX_NONCE_LEN: cfg_next.max_nonce_len = cfg_data[7:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_byte    <= START_BYTE_RST;
            cfg_reg.max_data_len  <= MAX_DATA_LEN_RST;
            cfg_reg.max_key_len   <= MAX_KEY_LEN_RST;
            cfg_reg.max_nonce_len <= MAX_NONCE_LEN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Hold the input side only while the queue is full
    assign in_stall = q_full;

    // Front: parse the byte stream, push one command per result-producing transfer
    crfr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_go    (!q_full),
        .mode     (mode),
        .rx_byte  (rx_byte),
        .cfg      (cfg_reg),
        .push     (q_push),
        .push_ent (q_push_ent)
    );

    crfr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_ent (q_push_ent),
        .pop      (q_pop),
        .full     (q_full),
        .nonempty (q_nonempty),
        .head     (q_head)
    );

    // Back: expand each command into one payload transfer or three reply transfers
    crfr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_nonempty (q_nonempty),
        .q_head     (q_head),
        .pop        (q_pop),
        .start_byte (cfg_reg.start_byte),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .section    (section),
        .value      (value),
        .offset     (offset),
        .status     (status),
        .algorithm  (algorithm),
        .data_len   (data_len),
        .key_len    (key_len),
        .nonce_len  (nonce_len),
        .last       (last)
    );

endmodule

// File: rtl/crfr_checker.sv
module crfr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  section,
    input logic [7:0]  value,
    input logic [15:0] offset,
    input logic [1:0]  status,
    input logic        last
);
    import crfr_pkg::*;

    // Payload transfers carry no status and never end a reply frame
    a_payload_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && section != SEC_REPLY) |-> (status == ST_BUSY && !last))
        else $error("payload transfer with reply status or last");

    // Reply transfers always carry a final status
    a_reply_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && section == SEC_REPLY) |-> (status != ST_BUSY))
        else $error("reply transfer without final status");

    // last marks exactly the CRC beat of a reply
    a_last_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && section == SEC_REPLY) |-> (last == (offset == 16'd2)))
        else $error("last does not match reply beat");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(value) && $stable(offset)))
        else $error("stalled result changed");

    // Handshake controls stay known out of reset
    a_ctrl_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({in_valid, in_stall, out_valid, out_stall}))
        else $error("handshake control unknown");

endmodule

bind crc8_request_frame_receiver_core crfr_checker u_crfr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .section   (section),
    .value     (value),
    .offset    (offset),
    .status    (status),
    .last      (last)
);

// File: tb/tb_crc8_request_frame_receiver_core.sv
module tb_crc8_request_frame_receiver_core;
    timeunit 1ns;
    timeprecision 1ps;

    import crfr_pkg::*;

    // Run control
    localparam int CYCLE_LIMIT = 400000; // watchdog, far above the slowest clean run
    localparam int SETTLE      = 8;      // cycles allowed after the last reply beat
    localparam int HOLD_AT     = 50;     // input transfers seen before the long hold-off
    localparam int HOLD_LEN    = 90;     // length of that hold-off in cycles
    localparam int QUIET_LO    = 180;    // window of input transfers with no idling
    localparam int QUIET_HI    = 330;
    localparam int RANDOM_PER_SETTING = 32;

    // One output transfer, field by field
    typedef struct packed {
        logic [1:0]  section;
        logic [7:0]  value;
        logic [15:0] offset;
        logic [1:0]  status;
        logic [7:0]  algorithm;
        logic [15:0] data_len;
        logic [7:0]  key_len;
        logic [7:0]  nonce_len;
        logic        last;
    } beat_t;

    // How a generated frame ends
    typedef enum logic [1:0] {
        FR_GOOD,
        FR_BAD_CRC,
        FR_CUT
    } frame_kind_t;

    // ------------------------------------------------------------------
    // Frame tracker: follows the receiver byte by byte and keeps the
    // output transfers that each input transfer must produce, in order.
    // ------------------------------------------------------------------
    class frame_tracker;
        cfg_t        cfg;
        phase_t      stage;
        logic [2:0]  hdr_pos;
        logic [7:0]  crc_run;
        logic [7:0]  hdr_algo;
        logic [15:0] hdr_dlen;
        logic [7:0]  hdr_klen;
        logic [7:0]  hdr_nlen;
        logic [15:0] sec_pos;
        beat_t       due_beats[$];
        int          errors;

        function new();
            cfg.start_byte    = START_BYTE_RST;
            cfg.max_data_len  = MAX_DATA_LEN_RST;
            cfg.max_key_len   = MAX_KEY_LEN_RST;
            cfg.max_nonce_len = MAX_NONCE_LEN_RST;
            stage    = PH_HUNT;
            hdr_pos  = '0;
            crc_run  = CRC_INIT;
            hdr_algo = '0;
            hdr_dlen = '0;
            hdr_klen = '0;
            hdr_nlen = '0;
            sec_pos  = '0;
            errors   = 0;
        endfunction

        // Serial form of the polynomial 0x07 CRC, one message bit at a time, MSB first
        static function logic [7:0] crc8_next(input logic [7:0] c, input logic [7:0] b);
            logic [7:0] r;
            logic       fb;
            r = c;
            for (int i = 7; i >= 0; i--)
            begin
                fb = r[7] ^ b[i];
                r  = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
            end
            return r;
        endfunction

        function void set_reg(input logic [1:0] idx, input logic [15:0] d);
            case (idx)
                CFG_START_BYTE:    cfg.start_byte    = d[7:0];
                CFG_MAX_DATA_LEN:  cfg.max_data_len  = d;
                CFG_MAX_KEY_LEN:   cfg.max_key_len   = d[7:0];
                default:           cfg.max_nonce_len = d[7:0];
            endcase
        endfunction

        function void push_beat(input logic [1:0] sec, input logic [7:0] val,
                                input logic [15:0] off, input logic [1:0] st,
                                input logic lst);
            beat_t e;
            e.section   = sec;
            e.value     = val;
            e.offset    = off;
            e.status    = st;
            e.algorithm = hdr_algo;
            e.data_len  = hdr_dlen;
            e.key_len   = hdr_klen;
            e.nonce_len = hdr_nlen;
            e.last      = lst;
            due_beats.push_back(e);
        endfunction

        // Three-beat answer: start byte, ack code, CRC of those two
        function void push_reply(input logic [7:0] ack, input logic [1:0] st);
            logic [7:0] c;
            c = crc8_next(crc8_next(CRC_INIT, cfg.start_byte), ack);
            push_beat(SEC_REPLY, cfg.start_byte, {14'd0, BEAT_START}, st, 1'b0);
            push_beat(SEC_REPLY, ack,            {14'd0, BEAT_ACK},   st, 1'b0);
            push_beat(SEC_REPLY, c,              {14'd0, BEAT_CRC},   st, 1'b1);
        endfunction

        // Move to the first non-empty section at or after the given one
        function void open_section(input phase_t from);
            sec_pos = '0;
            if (from <= PH_DATA && hdr_dlen != 16'd0)
                stage = PH_DATA;
            else if (from <= PH_KEY && hdr_klen != 8'd0)
                stage = PH_KEY;
            else if (from <= PH_NONCE && hdr_nlen != 8'd0)
                stage = PH_NONCE;
            else
                stage = PH_CRC;
        endfunction

        // Note one accepted input transfer and queue what it produces
        function void take_item(input logic m, input logic [7:0] b);
            logic [1:0]  sec;
            logic [15:0] len;
            logic        crc_ok;
            if (m)
            begin
                stage   = PH_HUNT;
                hdr_pos = '0;
                sec_pos = '0;
                crc_run = CRC_INIT;
                return;
            end
            case (stage)
                PH_HDR:
                begin
                    crc_run = crc8_next(crc_run, b);
                    case (hdr_pos)
                        3'd0:    hdr_algo       = b;
                        3'd1:    hdr_dlen[15:8] = b;
                        3'd2:    hdr_dlen[7:0]  = b;
                        3'd3:    hdr_klen       = b;
                        default: hdr_nlen       = b;
                    endcase
                    if (hdr_pos != HDR_LAST_IDX)
                        hdr_pos = hdr_pos + 3'd1;
                    else
                    begin
                        hdr_pos = '0;
                        if (hdr_klen > cfg.max_key_len || hdr_nlen > cfg.max_nonce_len ||
                            hdr_dlen > cfg.max_data_len)
                        begin
                            stage   = PH_HUNT;
                            crc_run = CRC_INIT;
                            push_reply(REPLY_NACK, ST_OVERFLOW);
                        end
                        else
                            open_section(PH_DATA);
                    end
                end
                PH_DATA, PH_KEY, PH_NONCE:
                begin
                    crc_run = crc8_next(crc_run, b);
                    if (stage == PH_DATA)
                    begin
                        sec = SEC_DATA;
                        len = hdr_dlen;
                    end
                    else if (stage == PH_KEY)
                    begin
                        sec = SEC_KEY;
                        len = {8'd0, hdr_klen};
                    end
                    else
                    begin
                        sec = SEC_NONCE;
                        len = {8'd0, hdr_nlen};
                    end
                    push_beat(sec, b, sec_pos, ST_BUSY, 1'b0);
                    if (({1'b0, sec_pos} + 17'd1) >= {1'b0, len})
                        open_section(phase_t'(stage + 3'd1));
                    else
                        sec_pos = sec_pos + 16'd1;
                end
                PH_CRC:
                begin
                    crc_ok  = (crc_run == b);
                    stage   = PH_HUNT;
                    crc_run = CRC_INIT;
                    sec_pos = '0;
                    if (crc_ok)
                        push_reply(REPLY_ACK, ST_OK);
                    else
                        push_reply(REPLY_NACK, ST_CRC_ERR);
                end
                default:
                begin
                    if (b == cfg.start_byte)
                    begin
                        stage   = PH_HDR;
                        hdr_pos = '0;
                        sec_pos = '0;
                        crc_run = crc8_next(CRC_INIT, b);
                    end
                end
            endcase
        endfunction

        function void cmp(input string name, input int unsigned want_v,
                          input int unsigned got_v);
            if (want_v != got_v)
            begin
                $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want_v, got_v);
                errors++;
            end
        endfunction

        // Check one accepted output transfer against the oldest queued beat
        function void check_beat(input beat_t got);
            beat_t want;
            if (due_beats.size() == 0)
            begin
                $error("output transfer with nothing queued: section %0d value 0x%0h offset %0d",
                       got.section, got.value, got.offset);
                errors++;
                return;
            end
            want = due_beats.pop_front();
            cmp("section",   want.section,   got.section);
            cmp("value",     want.value,     got.value);
            cmp("offset",    want.offset,    got.offset);
            cmp("status",    want.status,    got.status);
            cmp("algorithm", want.algorithm, got.algorithm);
            cmp("data_len",  want.data_len,  got.data_len);
            cmp("key_len",   want.key_len,   got.key_len);
            cmp("nonce_len", want.nonce_len, got.nonce_len);
            cmp("last",      want.last,      got.last);
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Block ports; every input starts at a known value
    // ------------------------------------------------------------------
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic        mode      = 1'b0;
    logic [7:0]  rx_byte   = 8'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  section;
    logic [7:0]  value;
    logic [15:0] offset;
    logic [1:0]  status;
    logic [7:0]  algorithm;
    logic [15:0] data_len;
    logic [7:0]  key_len;
    logic [7:0]  nonce_len;
    logic        last;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = 2'd0;
    logic [15:0] cfg_data  = 16'd0;

    frame_tracker tracker;
    cfg_t         cfg_cur;          // limits the stimulus builds frames against
    int           frame_items = 0;  // input transfers that belong to frames
    int           taken       = 0;  // all accepted input transfers
    int           cycles      = 0;
    int           hold_left   = 0;
    logic         hold_done   = 1'b0;
    logic         quiet;

    // Both sides stop idling for a while so back-to-back transfers get exercised
    assign quiet = (taken >= QUIET_LO) && (taken < QUIET_HI);

    crc8_request_frame_receiver_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .section   (section),
        .value     (value),
        .offset    (offset),
        .status    (status),
        .algorithm (algorithm),
        .data_len  (data_len),
        .key_len   (key_len),
        .nonce_len (nonce_len),
        .last      (last),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Watchdog: a hung block or a lost reply beat ends here
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver: random stall, one long hold-off once the run is under way,
    // and no stall at all inside the quiet window. The hold-off lets the
    // four-entry queue fill so the block has to stall its input.
    always @(posedge clk)
    begin
        if (!hold_done && taken >= HOLD_AT)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_LEN;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !quiet && ($urandom_range(99) < 26);
    end

    // Monitor: feed the tracker first, then check; an output beat only leaves
    // through the queue after its cause, so its expectation is already queued
    always @(posedge clk)
    begin : monitor
        beat_t got;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                tracker.take_item(mode, rx_byte);
                taken <= taken + 1;
            end
            if (out_valid && !out_stall)
            begin
                got.section   = section;
                got.value     = value;
                got.offset    = offset;
                got.status    = status;
                got.algorithm = algorithm;
                got.data_len  = data_len;
                got.key_len   = key_len;
                got.nonce_len = nonce_len;
                got.last      = last;
                tracker.check_beat(got);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus tasks
    // ------------------------------------------------------------------

    // Offer one input transfer; idle first at random, then hold the
    // payload steady until the block takes it
    task automatic send_item(input logic m, input logic [7:0] b);
        while (!quiet && $urandom_range(99) < 26)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Drop valid and wait until every queued beat has been checked
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.due_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic put_reg(input logic [1:0] idx, input logic [15:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        tracker.set_reg(idx, d);
    endtask

    // Write all four registers back to back while the block is idle
    task automatic apply_config(input cfg_t c);
        drain();
        put_reg(CFG_START_BYTE,    {8'd0, c.start_byte});
        put_reg(CFG_MAX_DATA_LEN,  c.max_data_len);
        put_reg(CFG_MAX_KEY_LEN,   {8'd0, c.max_key_len});
        put_reg(CFG_MAX_NONCE_LEN, {8'd0, c.max_nonce_len});
        cfg_we  <= 1'b0;
        cfg_cur = c;
    endtask

    // Build and send one frame. An oversize header stops after the header,
    // since the block answers it right away and hunts again.
    task automatic send_frame(input frame_kind_t kind, input logic [7:0] algo,
                              input logic [15:0] dl, input logic [7:0] kl,
                              input logic [7:0] nl);
        logic [7:0]  frame[$];
        logic [7:0]  crc;
        int unsigned body;
        int unsigned stop;
        frame.push_back(cfg_cur.start_byte);
        frame.push_back(algo);
        frame.push_back(dl[15:8]);
        frame.push_back(dl[7:0]);
        frame.push_back(kl);
        frame.push_back(nl);
        if (dl <= cfg_cur.max_data_len && kl <= cfg_cur.max_key_len &&
            nl <= cfg_cur.max_nonce_len)
        begin
            body = dl + kl + nl;
            repeat (body) frame.push_back(8'($urandom_range(255)));
            crc = CRC_INIT;
            foreach (frame[i])
                crc = frame_tracker::crc8_next(crc, frame[i]);
            if (kind == FR_BAD_CRC)
                crc = crc ^ 8'($urandom_range(255, 1));
            frame.push_back(crc);
        end
        stop = frame.size();
        if (kind == FR_CUT)
            stop = $urandom_range(frame.size() - 1, 1);
        for (int i = 0; i < stop; i++)
        begin
            send_item(1'b0, frame[i]);
            frame_items++;
        end
        // abandon the partial frame with a receive timeout
        if (kind == FR_CUT)
            send_item(1'b1, 8'($urandom_range(255)));
    endtask

    // Mostly short sections, now and then exactly at the limit when the limit is under 40
    function automatic int unsigned pick_len(input int unsigned lim);
        int unsigned top;
        top = (lim < 6) ? lim : 6;
        if ($urandom_range(4) == 0)
            return (lim < 40) ? lim : top;
        return $urandom_range(top);
    endfunction

    // Line noise between frames: a stray non-start byte or an idle timeout
    task automatic send_noise();
        logic [7:0] b;
        if ($urandom_range(1) == 1)
            send_item(1'b1, 8'($urandom_range(255)));
        else
        begin
            do
                b = 8'($urandom_range(255));
            while (b == cfg_cur.start_byte);
            send_item(1'b0, b);
        end
    endtask

    task automatic send_random_frame();
        int unsigned roll;
        frame_kind_t kind;
        logic [15:0] dl;
        logic [7:0]  kl;
        logic [7:0]  nl;
        roll = $urandom_range(99);
        if (roll >= 94)
        begin
            send_noise();
            return;
        end
        if (roll < 70)
            kind = FR_GOOD;
        else if (roll < 80)
            kind = FR_BAD_CRC;
        else if (roll < 86)
            kind = FR_CUT;
        else
            kind = FR_GOOD;
        dl = 16'(pick_len(cfg_cur.max_data_len));
        kl = 8'(pick_len(cfg_cur.max_key_len));
        nl = 8'(pick_len(cfg_cur.max_nonce_len));
        // push one length past its limit where the limit leaves room
        if (roll >= 86)
        begin
            case ($urandom_range(2))
                0:
                    if (cfg_cur.max_data_len != 16'hFFFF)
                        dl = 16'($urandom_range(65535, cfg_cur.max_data_len + 1));
                1:
                    if (cfg_cur.max_key_len != 8'hFF)
                        kl = 8'($urandom_range(255, cfg_cur.max_key_len + 1));
                default:
                    if (cfg_cur.max_nonce_len != 8'hFF)
                        nl = 8'($urandom_range(255, cfg_cur.max_nonce_len + 1));
            endcase
        end
        send_frame(kind, 8'($urandom_range(255)), dl, kl, nl);
    endtask

    task automatic run_random(input int quota);
        int first;
        first = frame_items;
        while (frame_items - first < quota)
            send_random_frame();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        cfg_t c;
        tracker = new();
        cfg_cur.start_byte    = START_BYTE_RST;
        cfg_cur.max_data_len  = MAX_DATA_LEN_RST;
        cfg_cur.max_key_len   = MAX_KEY_LEN_RST;
        cfg_cur.max_nonce_len = MAX_NONCE_LEN_RST;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed, reset limits: timeout and stray byte while hunting,
        // a frame with every section empty, an oversize data length,
        // one byte per section with a corrupted CRC, and a dropped frame
        send_item(1'b1, 8'hFF);
        send_item(1'b0, 8'h00);
        send_frame(FR_GOOD,    8'hFF, 16'd0,     8'd0, 8'd0);
        send_frame(FR_GOOD,    8'h00, 16'hFFFF,  8'd0, 8'd0);
        send_frame(FR_BAD_CRC, 8'hA5, 16'd1,     8'd1, 8'd1);
        send_frame(FR_CUT,     8'h5A, 16'd2,     8'd0, 8'd1);
        run_random(RANDOM_PER_SETTING);

        // All limits at zero: only empty frames pass, start byte 0x00
        c.start_byte    = 8'h00;
        c.max_data_len  = 16'd0;
        c.max_key_len   = 8'd0;
        c.max_nonce_len = 8'd0;
        apply_config(c);
        run_random(RANDOM_PER_SETTING);

        // All limits at full range, start byte 0xFF; one long frame
        // walks the offsets past the low byte
        c.start_byte    = 8'hFF;
        c.max_data_len  = 16'hFFFF;
        c.max_key_len   = 8'hFF;
        c.max_nonce_len = 8'hFF;
        apply_config(c);
        send_frame(FR_GOOD, 8'h3C, 16'd264, 8'd2, 8'd2);
        run_random(RANDOM_PER_SETTING);

        // Random small limits and start byte
        c.start_byte    = 8'($urandom_range(255));
        c.max_data_len  = 16'($urandom_range(40));
        c.max_key_len   = 8'($urandom_range(20));
        c.max_nonce_len = 8'($urandom_range(20));
        apply_config(c);
        run_random(RANDOM_PER_SETTING);

        drain();
        if (tracker.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: files.f
rtl/crfr_pkg.sv
rtl/crfr_front.sv
rtl/crfr_queue.sv
rtl/crfr_back.sv
rtl/crc8_request_frame_receiver_core.sv
rtl/crfr_checker.sv
tb/tb_crc8_request_frame_receiver_core.sv
